>>> src/lsef_pkg.sv
// lsef_pkg: shared types, opcodes, mode codes and constants of the led string effect store
// no dependencies; used by the interfaces, the effect alu, the top level and the checker
package lsef_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SEED    = 1'b1;

  // opcodes
  localparam logic [3:0] OP_PUSH_COLOR  = 4'd0;
  localparam logic [3:0] OP_PUSH_BEHAV  = 4'd1;
  localparam logic [3:0] OP_ROT_COLOR   = 4'd2;
  localparam logic [3:0] OP_ROT_BEHAV   = 4'd3;
  localparam logic [3:0] OP_SET_BULB    = 4'd4;
  localparam logic [3:0] OP_SET_LINE    = 4'd5;
  localparam logic [3:0] OP_ROT_STRINGS = 4'd6;
  localparam logic [3:0] OP_FADE_ALL    = 4'd7;
  localparam logic [3:0] OP_DRAW        = 4'd8;
  localparam logic [3:0] OP_FILL        = 4'd9;

  // bulb modes
  localparam logic [2:0] MODE_ON        = 3'd0;
  localparam logic [2:0] MODE_OFF       = 3'd1;
  localparam logic [2:0] MODE_BLINK     = 3'd2;
  localparam logic [2:0] MODE_TWINKLE   = 3'd3;
  localparam logic [2:0] MODE_FADE_DOWN = 3'd4;
  localparam logic [2:0] MODE_FADE_UPDN = 3'd5;

  // fade status codes
  localparam logic [1:0] FS_IDLE   = 2'd0;
  localparam logic [1:0] FS_FADING = 2'd1;
  localparam logic [1:0] FS_DONE   = 2'd2;

  // noise source and twinkle
  localparam logic [15:0] LFSR_TAPS     = 16'hB400;
  localparam logic [15:0] SEED_RESET    = 16'd44257;
  localparam logic [7:0]  LEVEL_RESET   = 8'd255;
  localparam logic [6:0]  TWINKLE_LIMIT = 7'd90;
  // ceil(2^23 / 100): quotient by 100 of a 16-bit value is (n * RECIP_100) >> 23
  localparam logic [16:0] RECIP_100     = 17'd83887;

  typedef struct packed {
    logic [3:0]  opcode;
    logic        direction;
    logic        all_strings;
    logic [2:0]  string_index;
    logic [2:0]  bulb_sel;
    logic [11:0] color;
    logic [2:0]  mode;
    logic [7:0]  target_level;
    logic [7:0]  step_rate;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_string;
    logic [2:0]  out_bulb;
    logic [11:0] out_color;
    logic [7:0]  out_level;
    logic [2:0]  out_mode;
    logic [7:0]  out_rate;
    logic [1:0]  fade_code;
    logic        last;
  } out_item_t;

  // one behavior store entry
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] level;
    logic [7:0] rate;
    logic [7:0] cur;
    logic       up;
  } behav_t;

  localparam behav_t BEHAV_RESET = '{mode: MODE_ON, level: LEVEL_RESET, rate: 8'd0,
                                     cur: LEVEL_RESET, up: 1'b0};

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PUSH_RD,
    S_PUSH_WR,
    S_LINE,
    S_FILL,
    S_FADE_RD,
    S_FADE_WR,
    S_DRAW_RD,
    S_DRAW_EX,
    S_DRAW_WB,
    S_RESP
  } state_t;

  // galois lfsr, shifted right
  function automatic logic [15:0] lfsr_next(input logic [15:0] l);
    logic [15:0] n;
    n = {1'b0, l[15:1]};
    if (l[0]) n = n ^ LFSR_TAPS;
    return n;
  endfunction

endpackage

>>> src/lsef_if.sv
// lsef_in_if / lsef_out_if: valid/ready stream channels of the led string effect store
// depends on lsef_pkg for the item types
interface lsef_in_if;
  logic               valid;
  logic               ready;
  lsef_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface lsef_out_if;
  logic                valid;
  logic                ready;
  lsef_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

>>> src/led_string_effect_store_unit.sv
// led_string_effect_store_unit: top level, sequencer, heads, valid bits and stores
// depends on lsef_pkg, lsef_if, lsef_ram and lsef_alu
//
// channel | dir | payload    | transfer when
// req     | in  | in_item_t  | req.valid & req.ready
// rsp     | out | out_item_t | rsp.valid & rsp.ready
// cfg     | in  | index/data | cfg_we
//
// one item at a time; ready only in the idle state
// rotations, set bulb, rotate strings and unknown opcodes act in dispatch, then respond; set line
// writes one bulb per string; push reads the store, then writes back, per string; fill writes every
// entry; fade all reads and writes back every entry; draw goes bulb by bulb through the shared effect unit
// a full result register stalls the sequencer; reset is synchronous, stores read as reset
// values through per-entry valid bits, so no clearing pass is needed
module led_string_effect_store_unit #(
  parameter int unsigned STRING_COUNT = 8,
  parameter int unsigned BULBS_EACH   = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  lsef_in_if.sink                            req,
  lsef_out_if.source                         rsp,
  input  logic                               cfg_we,
  input  logic [lsef_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsef_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lsef_pkg::*;

  localparam int unsigned DEPTH = STRING_COUNT * 8;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = (STRING_COUNT > 1) ? $clog2(STRING_COUNT) : 1;
  localparam logic [3:0]  SC_N  = 4'(STRING_COUNT);
  localparam logic [3:0]  BE_N  = 4'(BULBS_EACH);
  localparam logic [3:0]  SC_LAST = 4'(STRING_COUNT - 1);
  localparam logic [3:0]  BE_LAST = 4'(BULBS_EACH - 1);
  localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

  function automatic logic [2:0] wrap_add(input logic [2:0] h, input logic [2:0] b);
    logic [3:0] t;
    t = {1'b0, h} + {1'b0, b};
    if (t >= BE_N) t = t - BE_N;
    return t[2:0];
  endfunction

  function automatic logic [2:0] head_dn(input logic [2:0] h);
    return (h == 3'd0) ? BE_LAST[2:0] : h - 3'd1;
  endfunction

  function automatic logic [2:0] head_up(input logic [2:0] h);
    return ({1'b0, h} == BE_LAST) ? 3'd0 : h + 3'd1;
  endfunction

  function automatic logic [2:0] phys_of(input logic [2:0] s, input logic [2:0] off);
    logic [3:0] t;
    t = {1'b0, s} + SC_N - {1'b0, off};
    if (t >= SC_N) t = t - SC_N;
    return t[2:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [2:0] p, input logic [2:0] slot);
    logic [5:0] a;
    a = {p, slot};
    return a[AW-1:0];
  endfunction

  // control and working registers
  state_t        state, state_next;
  in_item_t      it;
  logic [2:0]    str;
  logic [2:0]    bulb;
  logic [AW-1:0] sweep;
  logic [1:0]    st_run;
  logic [2:0]    offset;
  logic [1:0]    fade_state;
  logic [15:0]   lfsr;
  logic [7:0]    default_level;
  logic [2:0]    color_head [STRING_COUNT];
  logic [2:0]    behav_head [STRING_COUNT];
  logic [DEPTH-1:0] cval, bval;
  logic          cval_q, bval_q;
  logic [2:0]    slot_q, phys_q;
  logic [AW-1:0] baddr_q;
  logic [32:0]   prod_q;
  logic          ov;
  out_item_t     out_q;

  // ram ports
  logic          c_we, c_re, b_we, b_re;
  logic [AW-1:0] c_waddr, c_raddr, b_waddr, b_raddr;
  logic [11:0]   c_wdata, c_rdata;
  behav_t        b_wdata, b_rdata;

  // derived values
  logic [2:0]  cur_phys, ch, bh_h, sel_head, push_slot;
  logic        si_ok, bi_ok, out_free, out_load, push_last, draw_last, needs_noise;
  logic [11:0] c_rd_v;
  behav_t      b_rd_v, alu_bh, fade_bh, new_bh, fill_bh;
  logic [11:0] alu_color, fill_color;
  logic [1:0]  st_new;
  logic [15:0] lfsr_step;
  out_item_t   out_next;

  lsef_ram #(.WIDTH(12), .DEPTH(DEPTH)) u_color_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
  );

  lsef_ram #(.WIDTH($bits(behav_t)), .DEPTH(DEPTH)) u_behav_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(b_re), .raddr(b_raddr), .rdata(b_rdata)
  );

  lsef_alu u_alu (
    .bh_in(b_rd_v), .color_in(c_rd_v), .noise(lfsr), .quot(prod_q[32:23]),
    .default_level(default_level), .bh_out(alu_bh), .color_out(alu_color)
  );

  // shared datapath terms
  always_comb begin
    cur_phys   = phys_of(str, offset);
    ch         = color_head[cur_phys[SW-1:0]];
    bh_h       = behav_head[cur_phys[SW-1:0]];
    sel_head   = (it.opcode == OP_PUSH_COLOR) ? ch : bh_h;
    push_slot  = it.direction ? head_dn(sel_head) : sel_head;
    si_ok      = {1'b0, it.string_index} < SC_N;
    bi_ok      = {1'b0, it.bulb_sel} < BE_N;
    out_free   = !ov || rsp.ready;
    push_last  = !it.all_strings || ({1'b0, str} == SC_LAST);
    draw_last  = ({1'b0, str} == SC_LAST) && ({1'b0, bulb} == BE_LAST);
    c_rd_v     = cval_q ? c_rdata : 12'd0;
    b_rd_v     = bval_q ? b_rdata : BEHAV_RESET;
    needs_noise = (b_rd_v.mode == MODE_BLINK) ||
                  ((b_rd_v.mode == MODE_TWINKLE) && (b_rd_v.cur == default_level));
    lfsr_step  = lfsr_next(lfsr);
    st_new     = (alu_bh.cur != 8'd0) ? FS_FADING : st_run;
    fade_bh      = b_rd_v;
    fade_bh.mode = MODE_FADE_DOWN;
    fade_bh.rate = it.step_rate;
    new_bh     = '{mode: it.mode, level: it.target_level, rate: it.step_rate,
                   cur: it.target_level, up: 1'b0};
    fill_color = (it.mode == MODE_ON) ? it.color : 12'd0;
    fill_bh.mode  = (it.mode == MODE_ON) ? MODE_ON : MODE_OFF;
    fill_bh.level = (it.mode == MODE_ON) ? default_level : 8'd0;
    fill_bh.rate  = 8'd0;
    fill_bh.cur   = fill_bh.level;
    fill_bh.up    = 1'b0;
  end

  // sequencer: next state, ram control, result
  always_comb begin
    state_next = state;
    c_we = 1'b0; c_waddr = '0; c_wdata = it.color;
    b_we = 1'b0; b_waddr = '0; b_wdata = new_bh;
    c_re = 1'b0; c_raddr = '0;
    b_re = 1'b0; b_raddr = '0;
    out_load = 1'b0;
    out_next = '0;
    out_next.fade_code = fade_state;
    out_next.last = 1'b1;
    case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (it.opcode)
          OP_PUSH_COLOR, OP_PUSH_BEHAV: begin
            state_next = (it.all_strings || si_ok) ? S_PUSH_RD : S_RESP;
          end
          OP_SET_BULB: begin
            if (si_ok && bi_ok) begin
              c_we    = 1'b1;
              c_waddr = addr_of(cur_phys, wrap_add(ch, it.bulb_sel));
            end
            state_next = S_RESP;
          end
          OP_SET_LINE: state_next = bi_ok ? S_LINE : S_RESP;
          OP_FADE_ALL: state_next = S_FADE_RD;
          OP_DRAW:     state_next = S_DRAW_RD;
          OP_FILL:     state_next = S_FILL;
          default:     state_next = S_RESP;
        endcase
      end
      S_LINE: begin
        c_we    = 1'b1;
        c_waddr = addr_of(cur_phys, wrap_add(ch, it.bulb_sel));
        if ({1'b0, str} == SC_LAST) state_next = S_RESP;
      end
      S_FILL: begin
        c_we = 1'b1; c_waddr = sweep; c_wdata = fill_color;
        b_we = 1'b1; b_waddr = sweep; b_wdata = fill_bh;
        if (sweep == ADDR_LAST) state_next = S_RESP;
      end
      S_FADE_RD: begin
        b_re = 1'b1; b_raddr = sweep;
        state_next = S_FADE_WR;
      end
      S_FADE_WR: begin
        b_we = 1'b1; b_waddr = sweep; b_wdata = fade_bh;
        state_next = (sweep == ADDR_LAST) ? S_RESP : S_FADE_RD;
      end
      S_PUSH_RD: begin
        c_re = (it.opcode == OP_PUSH_COLOR);
        b_re = (it.opcode == OP_PUSH_BEHAV);
        c_raddr = addr_of(cur_phys, push_slot);
        b_raddr = addr_of(cur_phys, push_slot);
        state_next = S_PUSH_WR;
      end
      S_PUSH_WR: begin
        if (out_free) begin
          out_load = 1'b1;
          out_next.out_string = str;
          out_next.last = push_last;
          if (it.opcode == OP_PUSH_COLOR) begin
            c_we = 1'b1; c_waddr = addr_of(phys_q, slot_q);
            out_next.out_color = c_rd_v;
          end else begin
            b_we = 1'b1; b_waddr = addr_of(phys_q, slot_q);
            out_next.out_level = b_rd_v.level;
            out_next.out_mode  = b_rd_v.mode;
            out_next.out_rate  = b_rd_v.rate;
          end
          state_next = push_last ? S_IDLE : S_PUSH_RD;
        end
      end
      S_DRAW_RD: begin
        c_re = 1'b1; c_raddr = addr_of(cur_phys, wrap_add(ch, bulb));
        b_re = 1'b1; b_raddr = addr_of(cur_phys, wrap_add(bh_h, bulb));
        state_next = S_DRAW_EX;
      end
      S_DRAW_EX: begin
        state_next = S_DRAW_WB;
      end
      S_DRAW_WB: begin
        if (out_free) begin
          b_we = 1'b1; b_waddr = baddr_q; b_wdata = alu_bh;
          out_load = 1'b1;
          out_next.out_string  = str;
          out_next.out_bulb    = bulb;
          out_next.out_color   = alu_color;
          out_next.out_level   = alu_bh.cur;
          out_next.fade_code   = st_new;
          out_next.last        = draw_last;
          state_next = draw_last ? S_IDLE : S_DRAW_RD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          if ((it.opcode == OP_ROT_COLOR || it.opcode == OP_ROT_BEHAV) &&
              !it.all_strings && si_ok) begin
            out_next.out_string = it.string_index;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = ov;
  assign rsp.item  = out_q;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // control state: heads, offset, fade status, noise, configuration, valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STRING_COUNT; i++) begin
        color_head[i] <= 3'd0;
        behav_head[i] <= 3'd0;
      end
      offset        <= 3'd0;
      fade_state    <= FS_IDLE;
      lfsr          <= SEED_RESET;
      default_level <= LEVEL_RESET;
      cval          <= '0;
      bval          <= '0;
      ov            <= 1'b0;
    end else begin
      // result register
      if (out_load) ov <= 1'b1;
      else if (rsp.ready) ov <= 1'b0;
      // store valid bits
      if (c_we) cval[c_waddr] <= 1'b1;
      if (b_we) bval[b_waddr] <= 1'b1;
      // operations done in the dispatch state
      if (state == S_DISPATCH) begin
        case (it.opcode)
          OP_ROT_COLOR, OP_ROT_BEHAV: begin
            if (it.all_strings) begin
              for (int i = 0; i < STRING_COUNT; i++) begin
                if (it.opcode == OP_ROT_COLOR) begin
                  color_head[i] <= it.direction ? head_up(color_head[i])
                                                : head_dn(color_head[i]);
                end else begin
                  behav_head[i] <= it.direction ? head_up(behav_head[i])
                                                : head_dn(behav_head[i]);
                end
              end
            end else if (si_ok) begin
              if (it.opcode == OP_ROT_COLOR) begin
                color_head[cur_phys[SW-1:0]] <= it.direction ? head_up(ch) : head_dn(ch);
              end else begin
                behav_head[cur_phys[SW-1:0]] <= it.direction ? head_up(bh_h) : head_dn(bh_h);
              end
            end
          end
          OP_ROT_STRINGS: begin
            if (it.direction) offset <= ({1'b0, offset} == SC_LAST) ? 3'd0 : offset + 3'd1;
            else offset <= (offset == 3'd0) ? SC_LAST[2:0] : offset - 3'd1;
          end
          OP_FADE_ALL: fade_state <= FS_FADING;
          default: begin
          end
        endcase
      end
      // head motion after a push
      if (state == S_PUSH_WR && out_free) begin
        if (it.opcode == OP_PUSH_COLOR) begin
          color_head[phys_q[SW-1:0]] <= it.direction ? slot_q : head_up(slot_q);
        end else begin
          behav_head[phys_q[SW-1:0]] <= it.direction ? slot_q : head_up(slot_q);
        end
      end
      // noise advances only for bulbs that draw on it
      if (state == S_DRAW_EX && needs_noise) lfsr <= lfsr_step;
      if (state == S_DRAW_WB && out_free && draw_last) fade_state <= st_new;
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEFAULT_LEVEL: default_level <= cfg_data[7:0];
          CFG_NOISE_SEED:    lfsr <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // working registers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      str    <= 3'd0;
      bulb   <= 3'd0;
      sweep  <= '0;
      st_run <= FS_DONE;
    end else begin
      if (state == S_IDLE && req.valid) begin
        str    <= ((req.item.opcode <= OP_ROT_BEHAV && req.item.all_strings) ||
                   req.item.opcode == OP_SET_LINE || req.item.opcode == OP_DRAW)
                  ? 3'd0 : req.item.string_index;
        bulb   <= 3'd0;
        sweep  <= '0;
        st_run <= FS_DONE;
      end
      if (state == S_LINE) str <= str + 3'd1;
      if (state == S_FILL || state == S_FADE_WR) sweep <= sweep + AW'(1);
      if (state == S_PUSH_WR && out_free) str <= str + 3'd1;
      if (state == S_DRAW_WB && out_free) begin
        st_run <= st_new;
        if ({1'b0, bulb} == BE_LAST) begin
          bulb <= 3'd0;
          str  <= str + 3'd1;
        end else begin
          bulb <= bulb + 3'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) it <= req.item;
    if (c_re) cval_q <= cval[c_raddr];
    if (b_re) bval_q <= bval[b_raddr];
    if (state == S_PUSH_RD) begin
      slot_q <= push_slot;
      phys_q <= cur_phys;
    end
    if (state == S_DRAW_RD) baddr_q <= b_raddr;
    if (state == S_DRAW_EX) prod_q <= lfsr_step * RECIP_100;
    if (out_load) out_q <= out_next;
  end
endmodule

>>> src/lsef_ram.sv
// lsef_ram: generic single-write, single-read ram with registered read data
// no dependencies
module lsef_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> src/lsef_alu.sv
// lsef_alu: shared effect unit, advances one bulb behavior per use during draw
// depends on lsef_pkg for behav_t and mode codes
module lsef_alu (
  input  lsef_pkg::behav_t bh_in,
  input  logic [11:0]      color_in,
  input  logic [15:0]      noise,
  input  logic [9:0]       quot,
  input  logic [7:0]       default_level,
  output lsef_pkg::behav_t bh_out,
  output logic [11:0]      color_out
);
  import lsef_pkg::*;

  logic [16:0] q_ext;
  logic [16:0] q_x100;
  logic [16:0] rem_full;
  logic [6:0]  rem;
  logic [8:0]  sum;

  // noise mod 100 from the registered quotient
  always_comb begin
    q_ext    = {7'd0, quot};
    q_x100   = (q_ext << 6) + (q_ext << 5) + (q_ext << 2);
    rem_full = {1'b0, noise} - q_x100;
    rem      = rem_full[6:0];
    sum      = {1'b0, bh_in.cur} + {1'b0, bh_in.rate};
  end

  // one behavior step
  always_comb begin
    bh_out    = bh_in;
    color_out = color_in;
    case (bh_in.mode)
      MODE_OFF: begin
        color_out = 12'd0;
      end
      MODE_BLINK: begin
        if (noise[0]) color_out = 12'd0;
      end
      MODE_TWINKLE: begin
        if (bh_in.cur != default_level) bh_out.cur = default_level;
        else bh_out.cur = (rem > TWINKLE_LIMIT) ? 8'd0 : default_level;
      end
      MODE_FADE_DOWN: begin
        if (bh_in.cur != 8'd0) begin
          bh_out.cur = (bh_in.cur >= bh_in.rate) ? bh_in.cur - bh_in.rate : 8'd0;
        end
      end
      MODE_FADE_UPDN: begin
        if (!bh_in.up) begin
          if (bh_in.cur < bh_in.rate) begin
            bh_out.cur = 8'd0;
            bh_out.up  = 1'b1;
          end else begin
            bh_out.cur = bh_in.cur - bh_in.rate;
          end
        end else begin
          if (sum > {1'b0, bh_in.level}) begin
            bh_out.cur = bh_in.level;
            bh_out.up  = 1'b0;
          end else begin
            bh_out.cur = sum[7:0];
          end
        end
      end
      default: begin
      end
    endcase
  end
endmodule

>>> src/lsef_checker.sv
// lsef_checker: port-level assertions for the led string effect store, bound to the top level
// depends on lsef_pkg for out_item_t
module lsef_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input lsef_pkg::out_item_t rsp_item
);
  import lsef_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
    else $error("result changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready right after an accepted item");

  // an item whose last result is not yet out keeps the input closed
  a_busy_until_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && !rsp_item.last |-> !req_ready)
    else $error("ready before the last result of an item");

  // popped behavior results carry no colour
  a_behav_no_color: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.out_mode != 3'd0 |-> rsp_item.out_color == 12'd0)
    else $error("colour on a behavior result");

  a_fade_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_item.fade_code != 2'd3)
    else $error("bad fade status");
endmodule

bind led_string_effect_store_unit lsef_checker u_lsef_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_item(rsp.item)
);

>>> tb/sv/tb_top.sv
// tb_top: self-checking testbench of led_string_effect_store_unit
// depends on lsef_pkg, lsef_if and the rtl; predicts every result of each transfer and compares
module tb_top;
  import lsef_pkg::*;

  localparam int unsigned NSTR = 8;
  localparam int unsigned NBLB = 8;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned IDLE_LIMIT = 20000;

  // own copy of one behavior entry
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] level;
    logic [7:0] rate;
    logic [7:0] cur;
    logic       up;
  } bulb_fx_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lsef_in_if req ();
  lsef_out_if rsp ();

  led_string_effect_store_unit #(.STRING_COUNT(NSTR), .BULBS_EACH(NBLB)) dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted store contents
  logic [11:0] shade_mem [NSTR][NBLB];
  bulb_fx_t    fx_mem [NSTR][NBLB];
  logic [2:0]  shade_head [NSTR];
  logic [2:0]  fx_head [NSTR];
  logic [2:0]  str_shift;
  logic [1:0]  fade_now;
  logic [15:0] noise;
  logic [7:0]  dflt_level;

  in_item_t  pending_q [$];
  out_item_t expected_q [$];
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned mismatches = 0;
  int unsigned idle_cycles;
  int unsigned hold_left;
  logic hold_req;

  function automatic out_item_t result_of(logic [2:0] s, logic [2:0] b, logic [11:0] c,
                                          logic [7:0] lv, logic [2:0] m, logic [7:0] r,
                                          logic [1:0] st, logic lst);
    out_item_t o;
    o.out_string = s; o.out_bulb = b; o.out_color = c; o.out_level = lv;
    o.out_mode = m; o.out_rate = r; o.fade_code = st; o.last = lst;
    return o;
  endfunction

  function automatic logic [15:0] noise_advance();
    logic [15:0] n;
    n = {1'b0, noise[15:1]};
    if (noise[0]) n = n ^ 16'hB400;
    noise = n;
    return n;
  endfunction

  task automatic store_reset();
    bulb_fx_t fx;
    fx = '{mode: MODE_ON, level: 8'd255, rate: 8'd0, cur: 8'd255, up: 1'b0};
    for (int s = 0; s < NSTR; s++) begin
      shade_head[s] = '0;
      fx_head[s] = '0;
      for (int b = 0; b < NBLB; b++) begin
        shade_mem[s][b] = '0;
        fx_mem[s][b] = fx;
      end
    end
    str_shift = '0;
    fade_now = FS_IDLE;
    dflt_level = 8'd255;
    noise = 16'd44257;
  endtask

  // one bulb step of a draw
  task automatic bulb_advance(inout bulb_fx_t fx, inout logic [11:0] c);
    logic [15:0] n;
    logic [8:0] sum;
    case (fx.mode)
      MODE_OFF: c = '0;
      MODE_BLINK: begin
        n = noise_advance();
        if (n[0]) c = '0;
      end
      MODE_TWINKLE: begin
        if (fx.cur != dflt_level) fx.cur = dflt_level;
        else begin
          n = noise_advance();
          fx.cur = ((n % 100) > 90) ? 8'd0 : dflt_level;
        end
      end
      MODE_FADE_DOWN: begin
        if (fx.cur > 0) fx.cur = (fx.cur > fx.rate) ? fx.cur - fx.rate : 8'd0;
      end
      MODE_FADE_UPDN: begin
        if (!fx.up) begin
          if (fx.cur < fx.rate) begin
            fx.cur = '0;
            fx.up = 1'b1;
          end else fx.cur = fx.cur - fx.rate;
        end else begin
          sum = {1'b0, fx.cur} + {1'b0, fx.rate};
          if (sum > {1'b0, fx.level}) begin
            fx.cur = fx.level;
            fx.up = 1'b0;
          end else fx.cur = sum[7:0];
        end
      end
      default: ;
    endcase
  endtask

  // predicts the results of one accepted item
  task automatic predict_effect(in_item_t it);
    logic [2:0] p, slot, lo;
    int hi;
    logic [11:0] c;
    logic [1:0] st;
    bulb_fx_t fx, nb;
    if (it.opcode <= OP_ROT_BEHAV) begin
      lo = it.all_strings ? 3'd0 : it.string_index;
      hi = it.all_strings ? NSTR : int'(it.string_index) + 1;
      if (it.opcode >= OP_ROT_COLOR) begin
        for (int s = lo; s < hi; s++) begin
          p = 3'(s) - str_shift;
          if (it.opcode == OP_ROT_COLOR)
            shade_head[p] = it.direction ? shade_head[p] + 3'd1 : shade_head[p] - 3'd1;
          else
            fx_head[p] = it.direction ? fx_head[p] + 3'd1 : fx_head[p] - 3'd1;
        end
        expected_q.push_back(result_of(it.all_strings ? 3'd0 : it.string_index, 0, 0, 0, 0,
                                       0, fade_now, 1'b1));
        return;
      end
      for (int s = lo; s < hi; s++) begin
        p = 3'(s) - str_shift;
        if (it.opcode == OP_PUSH_COLOR) begin
          slot = it.direction ? shade_head[p] - 3'd1 : shade_head[p];
          c = shade_mem[p][slot];
          shade_mem[p][slot] = it.color;
          shade_head[p] = it.direction ? slot : slot + 3'd1;
          expected_q.push_back(result_of(3'(s), 0, c, 0, 0, 0, fade_now, s + 1 == hi));
        end else begin
          slot = it.direction ? fx_head[p] - 3'd1 : fx_head[p];
          fx = fx_mem[p][slot];
          fx_mem[p][slot] = '{mode: it.mode, level: it.target_level, rate: it.step_rate,
                              cur: it.target_level, up: 1'b0};
          fx_head[p] = it.direction ? slot : slot + 3'd1;
          expected_q.push_back(result_of(3'(s), 0, 0, fx.level, fx.mode, fx.rate, fade_now,
                                         s + 1 == hi));
        end
      end
      return;
    end
    case (it.opcode)
      OP_SET_BULB: begin
        p = it.string_index - str_shift;
        shade_mem[p][shade_head[p] + it.bulb_sel] = it.color;
      end
      OP_SET_LINE: begin
        for (int s = 0; s < NSTR; s++) shade_mem[s][shade_head[s] + it.bulb_sel] = it.color;
      end
      OP_ROT_STRINGS: str_shift = it.direction ? str_shift + 3'd1 : str_shift - 3'd1;
      OP_FADE_ALL: begin
        fade_now = FS_FADING;
        for (int s = 0; s < NSTR; s++)
          for (int b = 0; b < NBLB; b++) begin
            fx_mem[s][b].mode = MODE_FADE_DOWN;
            fx_mem[s][b].rate = it.step_rate;
          end
      end
      OP_DRAW: begin
        st = FS_DONE;
        for (int s = 0; s < NSTR; s++) begin
          p = 3'(s) - str_shift;
          for (int b = 0; b < NBLB; b++) begin
            fx = fx_mem[p][fx_head[p] + 3'(b)];
            c = shade_mem[p][shade_head[p] + 3'(b)];
            bulb_advance(fx, c);
            fx_mem[p][fx_head[p] + 3'(b)] = fx;
            if (fx.cur > 0) st = FS_FADING;
            if (s == NSTR - 1 && b == NBLB - 1) fade_now = st;
            expected_q.push_back(result_of(3'(s), 3'(b), c, fx.cur, 0, 0, st,
                                           s == NSTR - 1 && b == NBLB - 1));
          end
        end
        return;
      end
      OP_FILL: begin
        c = (it.mode == MODE_ON) ? it.color : 12'd0;
        nb.mode = (it.mode == MODE_ON) ? MODE_ON : MODE_OFF;
        nb.level = (it.mode == MODE_ON) ? dflt_level : 8'd0;
        nb.rate = '0;
        nb.cur = nb.level;
        nb.up = 1'b0;
        for (int s = 0; s < NSTR; s++)
          for (int b = 0; b < NBLB; b++) begin
            shade_mem[s][b] = c;
            fx_mem[s][b] = nb;
          end
      end
      default: ;
    endcase
    expected_q.push_back(result_of(0, 0, 0, 0, 0, 0, fade_now, 1'b1));
  endtask

  function automatic in_item_t make_item(logic [3:0] op, logic dir, logic all_s,
                                         logic [2:0] si, logic [2:0] bi, logic [11:0] c,
                                         logic [2:0] m, logic [7:0] tl, logic [7:0] fr);
    in_item_t it;
    it.opcode = op; it.direction = dir; it.all_strings = all_s; it.string_index = si;
    it.bulb_sel = bi; it.color = c; it.mode = m; it.target_level = tl; it.step_rate = fr;
    return it;
  endfunction

  // random item, weighted toward pushes and draws of interesting behaviors
  function automatic in_item_t rand_item();
    in_item_t it;
    int unsigned w;
    logic [63:0] r;
    r = {$urandom, $urandom};
    it = r[$bits(in_item_t)-1:0];
    w = $urandom_range(99);
    if (w < 18) it.opcode = OP_PUSH_COLOR;
    else if (w < 36) it.opcode = OP_PUSH_BEHAV;
    else if (w < 44) it.opcode = OP_ROT_COLOR;
    else if (w < 52) it.opcode = OP_ROT_BEHAV;
    else if (w < 62) it.opcode = OP_SET_BULB;
    else if (w < 68) it.opcode = OP_SET_LINE;
    else if (w < 74) it.opcode = OP_ROT_STRINGS;
    else if (w < 77) it.opcode = OP_FADE_ALL;
    else if (w < 91) it.opcode = OP_DRAW;
    else if (w < 96) it.opcode = OP_FILL;
    else it.opcode = 4'($urandom_range(10, 15));
    if (it.opcode == OP_PUSH_BEHAV && $urandom_range(9) != 0) it.mode = 3'($urandom_range(5));
    if (it.opcode <= OP_ROT_BEHAV && $urandom_range(3) != 0) it.all_strings = 1'b0;
    if (it.opcode == OP_FADE_ALL || it.opcode == OP_PUSH_BEHAV)
      if ($urandom_range(1)) it.step_rate = 8'($urandom_range(40));
    if (it.opcode == OP_FILL && $urandom_range(1)) it.mode = MODE_ON;
    return it;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_DEFAULT_LEVEL) dflt_level = val[7:0];
    else begin
      noise = val;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // waits until every queued item is taken and every result checked
  task automatic wait_drained();
    while (pending_q.size() != 0 || req.valid || expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(int unsigned n, int unsigned idle_pct, int unsigned stall_pct);
    src_idle_pct = idle_pct;
    snk_stall_pct = stall_pct;
    pending_q.push_back(make_item(OP_FILL, 0, 0, 0, 0, 12'($urandom), MODE_ON, 0, 0));
    for (int i = 0; i < n; i++) pending_q.push_back(rand_item());
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // request driver: presents queued items, holds each until its transfer
  always @(posedge clk) begin : drive_req
    in_item_t ni;
    logic nv;
    if (rst) begin
      req.valid <= 1'b0;
      req.item <= '0;
    end else begin
      nv = req.valid;
      ni = req.item;
      if (req.valid && req.ready) begin
        predict_effect(req.item);
        nv = 1'b0;
      end
      if (!nv && pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        ni = pending_q.pop_front();
        nv = 1'b1;
      end
      req.valid <= nv;
      req.item <= ni;
    end
  end

  // response side: random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (hold_req) hold_left <= HOLD_CYCLES;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      rsp.ready <= (hold_req || hold_left > 1) ? 1'b0 : ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin : check_rsp
    out_item_t exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", rsp.item);
      end else begin
        exp_r = expected_q.pop_front();
        if (rsp.item !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp str %0d bulb %0d col %h lvl %0d mode %0d rate %0d st %0d last %0d",
                     exp_r.out_string, exp_r.out_bulb, exp_r.out_color, exp_r.out_level,
                     exp_r.out_mode, exp_r.out_rate, exp_r.fade_code, exp_r.last);
            $display("          got str %0d bulb %0d col %h lvl %0d mode %0d rate %0d st %0d last %0d",
                     rsp.item.out_string, rsp.item.out_bulb, rsp.item.out_color,
                     rsp.item.out_level, rsp.item.out_mode, rsp.item.out_rate,
                     rsp.item.fade_code, rsp.item.last);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // stimulus sequence
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    store_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: every opcode, field extremes, odd modes, unknown opcodes
    pending_q.push_back(make_item(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(OP_PUSH_COLOR, 1, 0, 0, 0, 12'hFFF, 0, 0, 0));
    pending_q.push_back(make_item(OP_PUSH_COLOR, 0, 0, 7, 7, 12'h0F0, 0, 0, 0));
    pending_q.push_back(make_item(OP_PUSH_COLOR, 1, 1, 3, 0, 12'h00F, 0, 0, 0));
    pending_q.push_back(make_item(OP_PUSH_BEHAV, 1, 0, 0, 0, 0, MODE_BLINK, 8'hFF, 8'd0));
    pending_q.push_back(make_item(OP_PUSH_BEHAV, 0, 0, 1, 0, 0, MODE_TWINKLE, 8'd0, 8'hFF));
    pending_q.push_back(make_item(OP_PUSH_BEHAV, 1, 1, 0, 0, 0, MODE_FADE_UPDN, 8'd200, 8'd60));
    pending_q.push_back(make_item(OP_PUSH_BEHAV, 0, 0, 2, 0, 0, 3'd6, 8'd10, 8'd1));
    pending_q.push_back(make_item(OP_PUSH_BEHAV, 1, 0, 7, 0, 0, 3'd7, 8'd20, 8'd2));
    pending_q.push_back(make_item(OP_PUSH_BEHAV, 0, 0, 5, 0, 0, MODE_OFF, 8'd50, 8'd3));
    pending_q.push_back(make_item(OP_ROT_COLOR, 1, 0, 2, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(OP_ROT_COLOR, 0, 1, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(OP_ROT_BEHAV, 1, 1, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(OP_ROT_BEHAV, 0, 0, 6, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(OP_SET_BULB, 0, 0, 7, 7, 12'hABC, 0, 0, 0));
    pending_q.push_back(make_item(OP_SET_LINE, 0, 0, 0, 0, 12'h123, 0, 0, 0));
    pending_q.push_back(make_item(OP_ROT_STRINGS, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(OP_ROT_STRINGS, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(OP_ROT_STRINGS, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(OP_DRAW, 1, 1, 7, 7, 12'hFFF, 7, 8'hFF, 8'hFF));
    pending_q.push_back(make_item(4'd15, 1, 1, 7, 7, 12'hFFF, 7, 8'hFF, 8'hFF));
    pending_q.push_back(make_item(OP_FADE_ALL, 0, 0, 0, 0, 0, 0, 0, 8'd100));
    pending_q.push_back(make_item(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_item(OP_FILL, 0, 0, 0, 0, 12'h5A5, MODE_OFF, 0, 0));
    pending_q.push_back(make_item(OP_DRAW, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // after the drain, sender never idles; long receiver hold while the block fills
    write_reg(CFG_DEFAULT_LEVEL, 16'd0);
    write_reg(CFG_NOISE_SEED, 16'd1);
    random_phase(85, 0, 0);
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    wait_drained();

    write_reg(CFG_DEFAULT_LEVEL, 16'd255);
    write_reg(CFG_NOISE_SEED, 16'hFFFF);
    random_phase(85, 81, 0);
    wait_drained();

    write_reg(CFG_DEFAULT_LEVEL, 16'($urandom_range(1, 254)));
    write_reg(CFG_NOISE_SEED, 16'($urandom_range(1, 65535)));
    random_phase(85, 0, 81);
    wait_drained();

    write_reg(CFG_DEFAULT_LEVEL, 16'd128);
    write_reg(CFG_NOISE_SEED, 16'($urandom_range(1, 65535)));
    random_phase(85, 22, 22);
    wait_drained();

    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

>>> led_string_effect_store_unit.f
src/lsef_pkg.sv
src/lsef_if.sv
src/lsef_ram.sv
src/lsef_alu.sv
src/led_string_effect_store_unit.sv
src/lsef_checker.sv
tb/sv/tb_top.sv
